[sv/i2cbb_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the bit-banged I2C master.
// No dependencies; used by i2cbb_fsm and the top level.
package i2cbb_pkg;

   localparam int BUF_DEPTH_DEF = 16;
   localparam int ACK_HOLD_DEF  = 5;
   localparam int ACK_CHECK_DEF = 10;
   localparam int BYTE_BITS     = 8;

   // Item kinds carried on req_tuser.
   localparam logic [2:0] OP_TICK  = 3'd0;
   localparam logic [2:0] OP_LOAD  = 3'd1;
   localparam logic [2:0] OP_WRITE = 3'd2;
   localparam logic [2:0] OP_READ  = 3'd3;
   localparam logic [2:0] OP_WR_RD = 3'd4;

   typedef struct packed {
      logic [2:0] op;
      logic [6:0] slave_addr;
      logic [4:0] byte_count;
      logic [4:0] prefix_count;
      logic [3:0] load_index;
      logic [7:0] load_data;
      logic       sda_in;
   } item_type;

   typedef struct packed {
      logic       scl_level;
      logic       sda_level;
      logic       sda_drive;
      logic       busy_res;
      logic       rx_valid;
      logic [7:0] rx_byte;
      logic [3:0] rx_index;
      logic       done_res;
      logic       failed;
   } result_type;

endpackage

[sv/i2cbb_txbuf.sv]
`timescale 1ns / 1ps
// Transmit byte store: one write port, one asynchronous read port.
// Depends on nothing but its parameter.
module i2cbb_txbuf #(
   parameter int BUF_DEPTH = 16,
   localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);

   logic [7:0] store_ff [BUF_DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   assign rd_data = store_ff[rd_addr];

endmodule

[sv/i2cbb_fsm.sv]
`timescale 1ns / 1ps
// Bus phase sequencer: applies one item to the registered bus state.
// Uses i2cbb_pkg types and op codes; reads the transmit store.
module i2cbb_fsm #(
   parameter int BUF_DEPTH       = 16,
   parameter int ACK_HOLD_TICKS  = 5,
   parameter int ACK_CHECK_TICKS = 10,
   localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step_en,
   input  i2cbb_pkg::item_type   item,
   input  logic [7:0]            tx_rd_data,
   output logic [AW-1:0]         tx_rd_addr,
   output i2cbb_pkg::result_type res
);

   localparam logic [3:0] PH_RESTART = 4'd0;
   localparam logic [3:0] PH_IDLE    = 4'd1;
   localparam logic [3:0] PH_START   = 4'd2;
   localparam logic [3:0] PH_STOP    = 4'd3;
   localparam logic [3:0] PH_RPT     = 4'd4;
   localparam logic [3:0] PH_SACK    = 4'd5;
   localparam logic [3:0] PH_SNACK   = 4'd6;
   localparam logic [3:0] PH_TX      = 4'd7;
   localparam logic [3:0] PH_RX      = 4'd8;
   localparam logic [3:0] PH_WAIT    = 4'd9;
   localparam logic [3:0] PH_GACK    = 4'd10;

   localparam logic [3:0] HOLD_N  = 4'(ACK_HOLD_TICKS);
   localparam logic [3:0] CHECK_N = 4'(ACK_CHECK_TICKS);
   localparam logic [3:0] BITS_N  = 4'(i2cbb_pkg::BYTE_BITS);

   logic [3:0] phase_ff, phase_in, ret_ff, ret_in, wait_ff, wait_in;
   logic [1:0] sub_ff, sub_in;
   logic [7:0] tx_shift_ff, tx_shift_in, rx_shift_ff, rx_shift_in;
   logic [7:0] addr_byte_ff, addr_byte_in;
   logic [3:0] bit_cnt_ff, bit_cnt_in, bit_inc;
   logic [4:0] tx_pos_ff, tx_pos_in, rx_pos_ff, rx_pos_in, rx_pos_inc;
   logic [4:0] phase_cnt_ff, phase_cnt_in, second_cnt_ff, second_cnt_in;
   logic       reading_ff, reading_in, rpt_pend_ff, rpt_pend_in, nack_ff, nack_in;
   logic       scl_ff, scl_in, sda_ff, sda_in_r, drv_ff, drv_in;
   logic       rx_v, done_p, fail_p;
   logic [7:0] rx_b;
   logic [3:0] rx_i;
   logic       idle;

   assign tx_rd_addr = AW'(32'(tx_pos_ff) % BUF_DEPTH);
   assign idle       = (phase_ff == PH_RESTART) || (phase_ff == PH_IDLE);
   assign bit_inc    = bit_cnt_ff + 4'd1;
   assign rx_pos_inc = rx_pos_ff + 5'd1;

   always_comb begin
      phase_in      = phase_ff;
      ret_in        = ret_ff;
      wait_in       = wait_ff;
      sub_in        = sub_ff;
      tx_shift_in   = tx_shift_ff;
      rx_shift_in   = rx_shift_ff;
      addr_byte_in  = addr_byte_ff;
      bit_cnt_in    = bit_cnt_ff;
      tx_pos_in     = tx_pos_ff;
      rx_pos_in     = rx_pos_ff;
      phase_cnt_in  = phase_cnt_ff;
      second_cnt_in = second_cnt_ff;
      reading_in    = reading_ff;
      rpt_pend_in   = rpt_pend_ff;
      nack_in       = nack_ff;
      scl_in        = scl_ff;
      sda_in_r      = sda_ff;
      drv_in        = drv_ff;
      rx_v          = 1'b0;
      rx_b          = 8'd0;
      rx_i          = 4'd0;
      done_p        = 1'b0;
      fail_p        = 1'b0;

      if ((item.op == i2cbb_pkg::OP_WRITE || item.op == i2cbb_pkg::OP_READ ||
           item.op == i2cbb_pkg::OP_WR_RD) && idle) begin
         // clear the per-transfer state, then arm the command
         rx_shift_in = 8'd0;
         rx_pos_in   = 5'd0;
         tx_pos_in   = 5'd0;
         bit_cnt_in  = 4'd0;
         rpt_pend_in = 1'b0;
         nack_in     = 1'b0;
         sub_in      = 2'd0;
         phase_in    = PH_START;
         if (item.op == i2cbb_pkg::OP_WRITE) begin
            reading_in   = 1'b0;
            phase_cnt_in = item.byte_count;
            tx_shift_in  = {item.slave_addr, 1'b0};
         end else if (item.op == i2cbb_pkg::OP_READ) begin
            reading_in   = 1'b1;
            phase_cnt_in = item.byte_count;
            tx_shift_in  = {item.slave_addr, 1'b1};
         end else begin
            rpt_pend_in   = 1'b1;
            reading_in    = 1'b0;
            addr_byte_in  = {item.slave_addr, 1'b0};
            tx_shift_in   = {item.slave_addr, 1'b0};
            phase_cnt_in  = item.prefix_count;
            second_cnt_in = item.byte_count;
         end
      end else if (item.op == i2cbb_pkg::OP_TICK) begin
         unique case (phase_ff)
            PH_START: begin
               drv_in  = 1'b1;
               phase_in = PH_WAIT;
               wait_in  = 4'd1;
               if (sub_ff == 2'd0) begin
                  sda_in_r = 1'b1; scl_in = 1'b1; sub_in = 2'd1; ret_in = PH_START;
               end else if (sub_ff == 2'd1) begin
                  sda_in_r = 1'b0; sub_in = 2'd2; ret_in = PH_START;
               end else begin
                  scl_in = 1'b0; sub_in = 2'd0; ret_in = PH_TX;
               end
            end
            PH_STOP: begin
               drv_in = 1'b1;
               if (sub_ff == 2'd0) begin
                  sda_in_r = 1'b0; scl_in = 1'b0; sub_in = 2'd1;
                  ret_in = PH_STOP; wait_in = 4'd1; phase_in = PH_WAIT;
               end else if (sub_ff == 2'd1) begin
                  scl_in = 1'b1; sub_in = 2'd2;
                  ret_in = PH_STOP; wait_in = 4'd1; phase_in = PH_WAIT;
               end else begin
                  sda_in_r = 1'b1; sub_in = 2'd0; phase_in = PH_RESTART;
                  done_p = 1'b1; fail_p = nack_ff;
               end
            end
            PH_RPT: begin
               rpt_pend_in  = 1'b0;
               reading_in   = 1'b1;
               phase_cnt_in = second_cnt_ff;
               tx_shift_in  = addr_byte_ff | 8'd1;
               rx_pos_in    = 5'd0;
               tx_pos_in    = 5'd0;
               bit_cnt_in   = 4'd0;
               sub_in       = 2'd0;
               phase_in     = PH_START;
            end
            PH_SACK: begin
               drv_in   = 1'b1;
               phase_in = PH_WAIT;
               wait_in  = HOLD_N;
               if (sub_ff == 2'd0) begin
                  sda_in_r = 1'b0; scl_in = 1'b1; sub_in = 2'd1; ret_in = PH_SACK;
               end else begin
                  scl_in = 1'b0; sda_in_r = 1'b1; sub_in = 2'd0; ret_in = PH_RX;
               end
            end
            PH_SNACK: begin
               drv_in   = 1'b1;
               phase_in = PH_WAIT;
               wait_in  = 4'd1;
               if (sub_ff == 2'd0) begin
                  sda_in_r = 1'b1; scl_in = 1'b1; sub_in = 2'd1; ret_in = PH_SNACK;
               end else begin
                  scl_in = 1'b0; sda_in_r = 1'b0; sub_in = 2'd0; ret_in = PH_STOP;
               end
            end
            PH_TX: begin
               drv_in   = 1'b1;
               phase_in = PH_WAIT;
               wait_in  = 4'd1;
               if (sub_ff == 2'd0) begin
                  if (bit_cnt_ff >= BITS_N) begin
                     bit_cnt_in = 4'd0; ret_in = PH_GACK;
                  end else begin
                     sda_in_r    = tx_shift_ff[7];
                     tx_shift_in = {tx_shift_ff[6:0], 1'b0};
                     bit_cnt_in  = bit_inc;
                     sub_in      = 2'd1;
                     scl_in      = 1'b1;
                     ret_in      = PH_TX;
                  end
               end else begin
                  scl_in = 1'b0; sub_in = 2'd0; ret_in = PH_TX;
               end
            end
            PH_RX: begin
               drv_in = 1'b0;
               if (sub_ff == 2'd0) begin
                  scl_in = 1'b1; sub_in = 2'd1;
                  ret_in = PH_RX; wait_in = 4'd1; phase_in = PH_WAIT;
               end else begin
                  scl_in      = 1'b0;
                  rx_shift_in = {rx_shift_ff[6:0], item.sda_in};
                  bit_cnt_in  = bit_inc;
                  sub_in      = 2'd0;
                  if (bit_inc >= BITS_N) begin
                     rx_v       = 1'b1;
                     rx_b       = {rx_shift_ff[6:0], item.sda_in};
                     rx_i       = rx_pos_ff[3:0];
                     rx_pos_in  = rx_pos_inc;
                     bit_cnt_in = 4'd0;
                     ret_in     = (rx_pos_inc >= phase_cnt_ff) ? PH_SNACK : PH_SACK;
                     wait_in    = 4'd1;
                     phase_in   = PH_WAIT;
                  end
               end
            end
            PH_WAIT: begin
               if (wait_ff <= 4'd1) begin
                  wait_in  = 4'd0;
                  phase_in = ret_ff;
               end else begin
                  wait_in = wait_ff - 4'd1;
               end
            end
            PH_GACK: begin
               drv_in   = 1'b0;
               phase_in = PH_WAIT;
               if (sub_ff == 2'd0) begin
                  scl_in = 1'b1; sub_in = 2'd1; ret_in = PH_GACK; wait_in = 4'd1;
               end else begin
                  scl_in  = 1'b0;
                  sub_in  = 2'd0;
                  wait_in = CHECK_N;
                  if (!item.sda_in) begin
                     drv_in = 1'b1;
                     if (!reading_ff) begin
                        if (tx_pos_ff >= phase_cnt_ff) begin
                           ret_in = rpt_pend_ff ? PH_RPT : PH_STOP;
                        end else begin
                           tx_shift_in = tx_rd_data;
                           tx_pos_in   = tx_pos_ff + 5'd1;
                           ret_in      = PH_TX;
                        end
                     end else begin
                        bit_cnt_in = 4'd0;
                        ret_in     = PH_RX;
                     end
                  end else begin
                     ret_in  = PH_STOP;
                     nack_in = 1'b1;
                  end
               end
            end
            PH_RESTART: begin
               rx_shift_in = 8'd0;
               rx_pos_in   = 5'd0;
               tx_pos_in   = 5'd0;
               bit_cnt_in  = 4'd0;
               rpt_pend_in = 1'b0;
               nack_in     = 1'b0;
               sub_in      = 2'd0;
               phase_in    = PH_IDLE;
            end
            PH_IDLE: begin
            end
            default: begin
               phase_in = PH_RESTART;
            end
         endcase
      end
   end

   always_comb begin
      res.scl_level = scl_in;
      res.sda_level = sda_in_r;
      res.sda_drive = drv_in;
      res.busy_res  = (phase_in != PH_RESTART) && (phase_in != PH_IDLE);
      res.rx_valid  = rx_v;
      res.rx_byte   = rx_b;
      res.rx_index  = rx_i;
      res.done_res  = done_p;
      res.failed    = fail_p;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_RESTART;
         ret_ff        <= 4'd0;
         wait_ff       <= 4'd0;
         sub_ff        <= 2'd0;
         tx_shift_ff   <= 8'd0;
         rx_shift_ff   <= 8'd0;
         addr_byte_ff  <= 8'd0;
         bit_cnt_ff    <= 4'd0;
         tx_pos_ff     <= 5'd0;
         rx_pos_ff     <= 5'd0;
         phase_cnt_ff  <= 5'd0;
         second_cnt_ff <= 5'd0;
         reading_ff    <= 1'b0;
         rpt_pend_ff   <= 1'b0;
         nack_ff       <= 1'b0;
         scl_ff        <= 1'b1;
         sda_ff        <= 1'b1;
         drv_ff        <= 1'b0;
      end else if (step_en) begin
         phase_ff      <= phase_in;
         ret_ff        <= ret_in;
         wait_ff       <= wait_in;
         sub_ff        <= sub_in;
         tx_shift_ff   <= tx_shift_in;
         rx_shift_ff   <= rx_shift_in;
         addr_byte_ff  <= addr_byte_in;
         bit_cnt_ff    <= bit_cnt_in;
         tx_pos_ff     <= tx_pos_in;
         rx_pos_ff     <= rx_pos_in;
         phase_cnt_ff  <= phase_cnt_in;
         second_cnt_ff <= second_cnt_in;
         reading_ff    <= reading_in;
         rpt_pend_ff   <= rpt_pend_in;
         nack_ff       <= nack_in;
         scl_ff        <= scl_in;
         sda_ff        <= sda_in_r;
         drv_ff        <= drv_in;
      end
   end

   // a failure is only ever reported together with completion
   a_fail_with_done: assert property (@(posedge clock) disable iff (reset)
      res.failed |-> res.done_res)
      else $error("failed raised without done");

   // a received byte is taken with SDA released and never on the stop beat
   a_rx_released: assert property (@(posedge clock) disable iff (reset)
      res.rx_valid |-> (!res.sda_drive && !res.done_res && res.busy_res))
      else $error("rx byte with SDA driven or on stop");

   // the delay phase always has ticks left to count
   a_wait_nonzero: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_WAIT) |-> (wait_ff != 4'd0))
      else $error("wait phase with empty tick count");

endmodule

[sv/i2c_bitbang_master.sv]
`timescale 1ns / 1ps
// Top level of the bit-banged I2C master: stream ports, input and result registers.
// Depends on i2cbb_pkg, i2cbb_txbuf and i2cbb_fsm.
//
// Each request beat carries one item: a tick that advances the sequencer by one step, a load of a
// byte into the transmit store, or a start command (write, read, write then repeated-start
// read). Every request beat yields exactly one response beat giving the pin levels, busy, any
// received byte, and a done/failed pulse when the stop completes. Start commands are ignored
// while a transfer is running. The block takes one beat per clock when the response side keeps
// up; a beat passes through the input register and the phase logic into the result register
// before its response appears. A stalled response holds the pipeline: the input register
// refills only as the result register drains.
module i2c_bitbang_master #(
   parameter int BUF_DEPTH       = i2cbb_pkg::BUF_DEPTH_DEF,
   parameter int ACK_HOLD_TICKS  = i2cbb_pkg::ACK_HOLD_DEF,
   parameter int ACK_CHECK_TICKS = i2cbb_pkg::ACK_CHECK_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // tdata from bit 0: slave_addr[6:0], byte_count[11:7], prefix_count[16:12],
   // load_index[20:17], load_data[28:21], sda_in[29], zero fill[31:30]
   input  logic [31:0] req_tdata,
   // tuser: op[2:0]
   input  logic [2:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // tdata from bit 0: scl_level[0], sda_level[1], sda_drive[2], busy_res[3], rx_valid[4],
   // rx_byte[12:5], rx_index[16:13], done_res[17], failed[18], zero fill[23:19]
   output logic [23:0] rsp_tdata
);

   localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;

   logic                  in_valid_ff;
   i2cbb_pkg::item_type   in_item_ff, req_item;
   logic                  out_valid_ff;
   i2cbb_pkg::result_type out_res_ff, step_res;
   logic                  advance;
   logic [AW-1:0]         tx_rd_addr, tx_wr_addr;
   logic [7:0]            tx_rd_data;

   // unpack the request beat
   always_comb begin
      req_item.op           = req_tuser;
      req_item.slave_addr   = req_tdata[6:0];
      req_item.byte_count   = req_tdata[11:7];
      req_item.prefix_count = req_tdata[16:12];
      req_item.load_index   = req_tdata[20:17];
      req_item.load_data    = req_tdata[28:21];
      req_item.sda_in       = req_tdata[29];
   end

   // advance the held item whenever the result register is free or draining
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tvalid && req_tready) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_item_ff <= req_item;
      end
   end

   assign tx_wr_addr = AW'(32'(in_item_ff.load_index) % BUF_DEPTH);

   i2cbb_txbuf #(
      .BUF_DEPTH (BUF_DEPTH)
   ) u_txbuf (
      .clock   (clock),
      .wr_en   (advance && (in_item_ff.op == i2cbb_pkg::OP_LOAD)),
      .wr_addr (tx_wr_addr),
      .wr_data (in_item_ff.load_data),
      .rd_addr (tx_rd_addr),
      .rd_data (tx_rd_data)
   );

   i2cbb_fsm #(
      .BUF_DEPTH       (BUF_DEPTH),
      .ACK_HOLD_TICKS  (ACK_HOLD_TICKS),
      .ACK_CHECK_TICKS (ACK_CHECK_TICKS)
   ) u_fsm (
      .clock      (clock),
      .reset      (reset),
      .step_en    (advance),
      .item       (in_item_ff),
      .tx_rd_data (tx_rd_data),
      .tx_rd_addr (tx_rd_addr),
      .res        (step_res)
   );

   // result register: load on advance, drop once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_res_ff <= step_res;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'd0, out_res_ff.failed, out_res_ff.done_res, out_res_ff.rx_index,
                        out_res_ff.rx_byte, out_res_ff.rx_valid, out_res_ff.busy_res,
                        out_res_ff.sda_drive, out_res_ff.sda_level, out_res_ff.scl_level};

endmodule
